// File: rtl/rhh_pkg.sv
// Package for the Robin Hood hash table: sizes, operation and status codes,
// sequencer states. No dependencies.
`timescale 1ns / 1ps
package rhh_pkg;
   localparam int CAPACITY_DEF   = 1024;
   localparam int VALUE_BITS_DEF = 32;
   localparam logic [9:0] MAX_ENTRIES_RESET = 10'd614;
   localparam logic [47:0] HASH_MASK = 48'hFFFF_FFFF_FFFF;

   typedef enum logic [2:0] {
      OP_INSERT  = 3'd0,
      OP_LOOKUP  = 3'd1,
      OP_DELETE  = 3'd2,
      OP_NEXT    = 3'd3,
      OP_RESTART = 3'd4,
      OP_CLEAR   = 3'd5,
      OP_RSVD6   = 3'd6,
      OP_RSVD7   = 3'd7
   } opcode_type;

   typedef enum logic [3:0] {
      ST_INSERTED = 4'd0,
      ST_REPLACED = 4'd1,
      ST_FOUND    = 4'd2,
      ST_ABSENT   = 4'd3,
      ST_DELETED  = 4'd4,
      ST_FULL     = 4'd5,
      ST_ITEM     = 4'd6,
      ST_END      = 4'd7,
      ST_DONE     = 4'd8
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_WIPE,
      S_FIND_RD,
      S_FIND_CHK,
      S_PUT_RD,
      S_PUT_CHK,
      S_DEL_RD,
      S_DEL_CHK,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_RESP
   } state_type;
endpackage

// File: rtl/rhh_slot_mem.sv
// Slot storage: key, value and probe distance arrays, one write and one
// registered read per cycle. Depends on rhh_pkg for nothing but sizing.
`timescale 1ns / 1ps
module rhh_slot_mem #(
   parameter int CAPACITY   = rhh_pkg::CAPACITY_DEF,
   parameter int VALUE_BITS = rhh_pkg::VALUE_BITS_DEF,
   localparam int AW = $clog2(CAPACITY),
   localparam int DW = AW + 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  logic [63:0]           wr_key,
   input  logic [VALUE_BITS-1:0] wr_value,
   input  logic [DW-1:0]         wr_dist,
   input  logic [AW-1:0]         rd_addr,
   output logic [63:0]           rd_key,
   output logic [VALUE_BITS-1:0] rd_value,
   output logic [DW-1:0]         rd_dist
);
   logic [63:0]           key_mem  [CAPACITY];
   logic [VALUE_BITS-1:0] val_mem  [CAPACITY];
   logic [DW-1:0]         dist_mem [CAPACITY];

   // One write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr]  <= wr_key;
         val_mem[wr_addr]  <= wr_value;
         dist_mem[wr_addr] <= wr_dist;
      end
      rd_key   <= key_mem[rd_addr];
      rd_value <= val_mem[rd_addr];
      rd_dist  <= dist_mem[rd_addr];
   end
endmodule

// File: rtl/robin_hood_hash_table_top.sv
// An operation holds the block from its accepting cycle to its result transfer. Restart
// and unused codes go straight to the result; lookup, insert, delete and iterate read
// and then check each slot in turn, and clear wipes every slot. The result is offered
// the cycle after the last check; one operation at a time, the next accepted the cycle
// after the result transfer. After reset a clearing pass empties every slot before the
// first transfer is accepted; max_entries resets to 614.
`timescale 1ns / 1ps
module robin_hood_hash_table_top #(
   parameter int CAPACITY   = rhh_pkg::CAPACITY_DEF,
   parameter int VALUE_BITS = rhh_pkg::VALUE_BITS_DEF,
   localparam int AW = $clog2(CAPACITY),
   localparam int DW = AW + 1
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [9:0]   csr_wr_data,
   input  logic         req_tvalid,
   output logic         req_tready,
   // opcode[2:0], key[66:3], value[98:67], zero fill to 104
   input  logic [103:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[3:0], key_out[67:4], value_out[99:68], entry_count[110:100], zero fill
   output logic [111:0] rsp_tdata
);
   localparam logic [DW-1:0] ONE_D = DW'(1);
   localparam logic [DW-1:0] CAP_D = DW'(CAPACITY);

   rhh_pkg::state_type state_ff, state_in;

   logic [9:0]            max_ff;
   logic [2:0]            op_ff, op_in;
   logic [63:0]           key_ff, key_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [AW-1:0]         pos_ff, pos_in;
   logic [DW-1:0]         steps_ff, steps_in;
   logic [DW-1:0]         count_ff, count_in;
   logic [DW-1:0]         scan_ff, scan_in;
   logic [63:0]           ckey_ff, ckey_in;
   logic [VALUE_BITS-1:0] cval_ff, cval_in;
   logic [DW-1:0]         cdist_ff, cdist_in;
   logic [3:0]            st_ff, st_in;
   logic [63:0]           okey_ff, okey_in;
   logic [31:0]           oval_ff, oval_in;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [63:0]           wr_key, rd_key;
   logic [VALUE_BITS-1:0] wr_value, rd_value;
   logic [DW-1:0]         wr_dist, rd_dist;

   logic [63:0]           in_key;
   logic [AW-1:0]         home;
   logic                  full_cond;

   rhh_slot_mem #(.CAPACITY(CAPACITY), .VALUE_BITS(VALUE_BITS)) u_mem (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_key(wr_key),
      .wr_value(wr_value), .wr_dist(wr_dist), .rd_addr(rd_addr),
      .rd_key(rd_key), .rd_value(rd_value), .rd_dist(rd_dist)
   );

   assign in_key = req_tdata[66:3];
   assign home   = AW'(in_key[47:0] & rhh_pkg::HASH_MASK);
   assign req_tready = (state_ff == rhh_pkg::S_IDLE);
   assign rsp_tvalid = (state_ff == rhh_pkg::S_RESP);
   assign rsp_tdata  = {1'b0, 11'(count_ff), oval_ff, okey_ff, st_ff};
   assign full_cond = ({1'b0, count_ff} >= (DW+1)'(max_ff)) ||
                      ((DW+1)'(count_ff) + (DW+1)'(1) >= (DW+1)'(CAPACITY));

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) max_ff <= rhh_pkg::MAX_ENTRIES_RESET;
      else if (csr_wr_en) max_ff <= csr_wr_data;
   end

   // Control and carried state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rhh_pkg::S_WIPE;
         op_ff    <= rhh_pkg::OP_INSERT;
         pos_ff   <= '0;
         count_ff <= '0;
         scan_ff  <= '0;
         cdist_ff <= '0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         pos_ff   <= pos_in;
         count_ff <= count_in;
         scan_ff  <= scan_in;
         cdist_ff <= cdist_in;
      end
      key_ff <= key_in; val_ff <= val_in; steps_ff <= steps_in;
      ckey_ff <= ckey_in; cval_ff <= cval_in; st_ff <= st_in;
      okey_ff <= okey_in; oval_ff <= oval_in;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rhh_pkg::S_IDLE: begin
            if (req_tvalid) begin
               unique case (rhh_pkg::opcode_type'(req_tdata[2:0]))
                  rhh_pkg::OP_INSERT, rhh_pkg::OP_LOOKUP, rhh_pkg::OP_DELETE:
                     state_in = rhh_pkg::S_FIND_RD;
                  rhh_pkg::OP_NEXT:  state_in = rhh_pkg::S_SCAN_RD;
                  rhh_pkg::OP_CLEAR: state_in = rhh_pkg::S_WIPE;
                  default:           state_in = rhh_pkg::S_RESP;
               endcase
            end
         end
         rhh_pkg::S_WIPE:
            if (pos_ff == AW'(CAPACITY - 1))
               state_in = (op_ff == rhh_pkg::OP_CLEAR) ? rhh_pkg::S_RESP : rhh_pkg::S_IDLE;
         rhh_pkg::S_FIND_RD: state_in = rhh_pkg::S_FIND_CHK;
         rhh_pkg::S_FIND_CHK: begin
            if (rd_dist == '0 || steps_ff == CAP_D) begin
               if (op_ff == rhh_pkg::OP_INSERT && !full_cond && steps_ff != CAP_D)
                  state_in = rhh_pkg::S_PUT_RD;
               else state_in = rhh_pkg::S_RESP;
            end else if (rd_key == key_ff) begin
               state_in = (op_ff == rhh_pkg::OP_DELETE) ? rhh_pkg::S_DEL_RD : rhh_pkg::S_RESP;
            end else state_in = rhh_pkg::S_FIND_RD;
         end
         rhh_pkg::S_PUT_RD: state_in = rhh_pkg::S_PUT_CHK;
         rhh_pkg::S_PUT_CHK:
            state_in = (rd_dist == '0 || steps_ff == CAP_D) ? rhh_pkg::S_RESP
                                                            : rhh_pkg::S_PUT_RD;
         rhh_pkg::S_DEL_RD: state_in = rhh_pkg::S_DEL_CHK;
         rhh_pkg::S_DEL_CHK:
            state_in = (rd_dist <= ONE_D || steps_ff == CAP_D) ? rhh_pkg::S_RESP
                                                               : rhh_pkg::S_DEL_RD;
         rhh_pkg::S_SCAN_RD:
            state_in = (scan_ff >= CAP_D) ? rhh_pkg::S_RESP : rhh_pkg::S_SCAN_CHK;
         rhh_pkg::S_SCAN_CHK:
            state_in = (rd_dist != '0) ? rhh_pkg::S_RESP : rhh_pkg::S_SCAN_RD;
         rhh_pkg::S_RESP: if (rsp_tready) state_in = rhh_pkg::S_IDLE;
         default: state_in = rhh_pkg::S_IDLE;
      endcase
   end

   // Datapath and memory port control.
   always_comb begin
      op_in = op_ff; key_in = key_ff; val_in = val_ff; pos_in = pos_ff;
      steps_in = steps_ff; count_in = count_ff; scan_in = scan_ff;
      ckey_in = ckey_ff; cval_in = cval_ff; cdist_in = cdist_ff;
      st_in = st_ff; okey_in = okey_ff; oval_in = oval_ff;
      wr_en = 1'b0; wr_addr = pos_ff; wr_key = ckey_ff; wr_value = cval_ff;
      wr_dist = cdist_ff; rd_addr = pos_ff;
      unique case (state_ff)
         rhh_pkg::S_IDLE: begin
            if (req_tvalid) begin
               op_in = req_tdata[2:0];
               key_in = in_key;
               val_in = VALUE_BITS'(req_tdata[98:67]);
               okey_in = in_key;
               oval_in = '0;
               st_in = rhh_pkg::ST_DONE;
               steps_in = '0;
               pos_in = home;
               if (req_tdata[2:0] == rhh_pkg::OP_DELETE ||
                   req_tdata[2:0] == rhh_pkg::OP_RESTART)
                  scan_in = '0;
               if (req_tdata[2:0] == rhh_pkg::OP_NEXT) st_in = rhh_pkg::ST_END;
               if (req_tdata[2:0] == rhh_pkg::OP_CLEAR) begin
                  pos_in = '0;
                  count_in = '0;
               end
            end
         end
         rhh_pkg::S_WIPE: begin
            wr_en = 1'b1; wr_dist = '0;
            pos_in = pos_ff + AW'(1);
         end
         rhh_pkg::S_FIND_RD: steps_in = steps_ff + ONE_D;
         rhh_pkg::S_FIND_CHK: begin
            if (rd_dist == '0 || steps_ff == CAP_D) begin
               pos_in = key_ff[AW-1:0];
               steps_in = '0;
               ckey_in = key_ff; cval_in = val_ff; cdist_in = ONE_D;
               unique case (op_ff)
                  rhh_pkg::OP_INSERT: st_in = (full_cond || steps_ff == CAP_D)
                                              ? rhh_pkg::ST_FULL : rhh_pkg::ST_INSERTED;
                  default: st_in = rhh_pkg::ST_ABSENT;
               endcase
            end else if (rd_key == key_ff) begin
               oval_in = 32'(rd_value);
               steps_in = '0;
               unique case (op_ff)
                  rhh_pkg::OP_INSERT: begin
                     st_in = rhh_pkg::ST_REPLACED;
                     wr_en = 1'b1; wr_key = rd_key; wr_value = val_ff; wr_dist = rd_dist;
                  end
                  rhh_pkg::OP_DELETE: begin
                     st_in = rhh_pkg::ST_DELETED;
                     wr_en = 1'b1; wr_key = rd_key; wr_value = rd_value; wr_dist = '0;
                     pos_in = pos_ff + AW'(1);
                     count_in = (count_ff != '0) ? count_ff - ONE_D : count_ff;
                  end
                  default: st_in = rhh_pkg::ST_FOUND;
               endcase
            end else pos_in = pos_ff + AW'(1);
         end
         rhh_pkg::S_PUT_RD: steps_in = steps_ff + ONE_D;
         rhh_pkg::S_PUT_CHK: begin
            // Swap the carried entry into any slot that sits closer to home.
            if (rd_dist == '0) begin
               wr_en = 1'b1;
               count_in = count_ff + ONE_D;
            end else if (rd_dist < cdist_ff) begin
               wr_en = 1'b1;
               ckey_in = rd_key; cval_in = rd_value; cdist_in = rd_dist + ONE_D;
            end else cdist_in = cdist_ff + ONE_D;
            pos_in = pos_ff + AW'(1);
         end
         rhh_pkg::S_DEL_RD: steps_in = steps_ff + ONE_D;
         rhh_pkg::S_DEL_CHK: begin
            // Move the following entry back one slot, or end the shift.
            wr_en = 1'b1;
            wr_addr = pos_ff - AW'(1);
            wr_key = rd_key; wr_value = rd_value;
            wr_dist = (rd_dist <= ONE_D) ? '0 : rd_dist - ONE_D;
            if (rd_dist > ONE_D && steps_ff != CAP_D) begin
               wr_en = 1'b1;
               pos_in = pos_ff + AW'(1);
            end else if (steps_ff == CAP_D && rd_dist > ONE_D) begin
               wr_en = 1'b1;
            end
         end
         rhh_pkg::S_SCAN_RD: begin
            rd_addr = AW'(scan_ff);
            if (scan_ff < CAP_D) scan_in = scan_ff + ONE_D;
         end
         rhh_pkg::S_SCAN_CHK: begin
            if (rd_dist != '0) begin
               st_in = rhh_pkg::ST_ITEM;
               okey_in = rd_key;
               oval_in = 32'(rd_value);
            end
         end
         rhh_pkg::S_RESP: ;
         default: ;
      endcase
   end

   // Count never exceeds the table size.
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_D) else $error("entry count overflow");
   // Result stays put until taken.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   // No input is taken while a result is pending.
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("overlap");
endmodule

// File: sim/robin_hood_hash_table_top_test.sv
// Self-checking testbench for the Robin Hood hash table: random stream traffic on both sides,
// with a built-in table predictor checked against every result transfer.
// Depends on rhh_pkg and robin_hood_hash_table_top.
`timescale 1ns / 1ps
module robin_hood_hash_table_top_test;
   localparam int SLOTS = 1024;
   localparam int IDLE_LIMIT = 20000;

   typedef struct packed {
      rhh_pkg::opcode_type op;
      logic [63:0]         key;
      logic [31:0]         value;
   } table_op_type;

   typedef struct packed {
      rhh_pkg::status_type status;
      logic [63:0]         key;
      logic [31:0]         value;
      logic [10:0]         count;
   } table_result_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_wr_en = 1'b0;
   logic [9:0]   csr_wr_data = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [103:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [111:0] rsp_tdata;

   robin_hood_hash_table_top dut (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the table contents and its registers.
   logic [63:0] shadow_key [SLOTS];
   logic [31:0] shadow_val [SLOTS];
   int unsigned shadow_dist [SLOTS];
   int unsigned shadow_count;
   int unsigned shadow_scan;
   int unsigned shadow_limit;

   table_op_type     pending_ops[$];
   table_result_type expected_results[$];
   logic [63:0]      key_pool[$];
   int               failures = 0;
   bit               calm = 1'b0;

   function automatic bit shadow_find(input logic [63:0] key, output int unsigned pos);
      int unsigned i;
      i = 32'(key[9:0]);
      pos = 0;
      for (int n = 0; n < SLOTS; n++) begin
         if (shadow_dist[i] == 0) return 1'b0;
         if (shadow_key[i] == key) begin
            pos = i;
            return 1'b1;
         end
         i = (i + 1) % SLOTS;
      end
      return 1'b0;
   endfunction

   // Linear probe that hands each slot to whichever entry sits further from home.
   function automatic void shadow_place(input logic [63:0] key, input logic [31:0] value);
      logic [63:0] ck, tk;
      logic [31:0] cv, tv;
      int unsigned cd, td, i;
      ck = key;
      cv = value;
      cd = 1;
      i = 32'(key[9:0]);
      for (int n = 0; n < SLOTS; n++) begin
         if (shadow_dist[i] == 0) begin
            shadow_key[i] = ck;
            shadow_val[i] = cv;
            shadow_dist[i] = cd;
            shadow_count++;
            return;
         end
         if (shadow_dist[i] < cd) begin
            tk = shadow_key[i];
            tv = shadow_val[i];
            td = shadow_dist[i];
            shadow_key[i] = ck;
            shadow_val[i] = cv;
            shadow_dist[i] = cd;
            ck = tk;
            cv = tv;
            cd = td;
         end
         i = (i + 1) % SLOTS;
         cd++;
      end
   endfunction

   // Backward-shift delete: later entries of the run move one slot closer to home.
   function automatic void shadow_remove(input int unsigned pos);
      int unsigned prev, nx;
      prev = pos;
      shadow_dist[pos] = 0;
      for (int n = 0; n < SLOTS; n++) begin
         nx = (prev + 1) % SLOTS;
         if (shadow_dist[nx] <= 1) begin
            shadow_dist[prev] = 0;
            break;
         end
         shadow_key[prev] = shadow_key[nx];
         shadow_val[prev] = shadow_val[nx];
         shadow_dist[prev] = shadow_dist[nx] - 1;
         prev = nx;
      end
      if (shadow_count > 0) shadow_count--;
   endfunction

   function automatic table_result_type shadow_apply(input table_op_type item);
      table_result_type r;
      int unsigned pos;
      int unsigned s;
      r.status = rhh_pkg::ST_DONE;
      r.key = item.key;
      r.value = '0;
      case (item.op)
         rhh_pkg::OP_INSERT: begin
            if (shadow_find(item.key, pos)) begin
               r.value = shadow_val[pos];
               shadow_val[pos] = item.value;
               r.status = rhh_pkg::ST_REPLACED;
            end else if (shadow_count >= shadow_limit || shadow_count + 1 >= SLOTS) begin
               r.status = rhh_pkg::ST_FULL;
            end else begin
               shadow_place(item.key, item.value);
               r.status = rhh_pkg::ST_INSERTED;
            end
         end
         rhh_pkg::OP_LOOKUP: begin
            if (shadow_find(item.key, pos)) begin
               r.value = shadow_val[pos];
               r.status = rhh_pkg::ST_FOUND;
            end else begin
               r.status = rhh_pkg::ST_ABSENT;
            end
         end
         rhh_pkg::OP_DELETE: begin
            shadow_scan = 0;
            if (shadow_find(item.key, pos)) begin
               r.value = shadow_val[pos];
               shadow_remove(pos);
               r.status = rhh_pkg::ST_DELETED;
            end else begin
               r.status = rhh_pkg::ST_ABSENT;
            end
         end
         rhh_pkg::OP_NEXT: begin
            r.status = rhh_pkg::ST_END;
            while (shadow_scan < SLOTS) begin
               s = shadow_scan;
               shadow_scan++;
               if (shadow_dist[s] != 0) begin
                  r.key = shadow_key[s];
                  r.value = shadow_val[s];
                  r.status = rhh_pkg::ST_ITEM;
                  break;
               end
            end
         end
         rhh_pkg::OP_RESTART: shadow_scan = 0;
         rhh_pkg::OP_CLEAR: begin
            for (int k = 0; k < SLOTS; k++) shadow_dist[k] = 0;
            shadow_count = 0;
         end
         default: ;
      endcase
      r.count = shadow_count[10:0];
      return r;
   endfunction

   // Mostly short gaps, a few long ones, none at all while calm.
   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Request driver: offers queued operations and predicts each accepted transfer.
   int           send_gap = 0;
   table_op_type offered;
   always @(posedge clock) begin
      bit holding;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         holding = req_tvalid;
         if (req_tvalid && req_tready) begin
            expected_results.push_back(shadow_apply(offered));
            holding = 1'b0;
            send_gap = pick_gap();
            if ($urandom_range(0, 79) == 0) calm = !calm;
         end
         if (!holding) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
               offered = pending_ops.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {5'b0, offered.value, offered.key, offered.op};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: compares each transfer with the oldest prediction.
   int  results_seen = 0;
   int  rsp_hold = 0;
   bit  long_hold_done = 1'b0;
   always @(posedge clock) begin
      table_result_type    want;
      rhh_pkg::status_type got_status;
      logic [63:0]         got_key;
      logic [31:0]         got_value;
      logic [10:0]         got_count;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_status = rhh_pkg::status_type'(rsp_tdata[3:0]);
            got_key = rsp_tdata[67:4];
            got_value = rsp_tdata[99:68];
            got_count = rsp_tdata[110:100];
            results_seen++;
            if (expected_results.size() == 0) begin
               failures++;
               $display("%0t: unexpected result transfer, status %0d key %h",
                        $time, got_status, got_key);
            end else begin
               want = expected_results.pop_front();
               if (got_status !== want.status) begin
                  failures++;
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, got_status);
               end
               if (got_key !== want.key) begin
                  failures++;
                  $display("%0t: key_out expected %h actual %h", $time, want.key, got_key);
               end
               if (got_value !== want.value) begin
                  failures++;
                  $display("%0t: value_out expected %h actual %h",
                           $time, want.value, got_value);
               end
               if (got_count !== want.count) begin
                  failures++;
                  $display("%0t: entry_count expected %0d actual %0d",
                           $time, want.count, got_count);
               end
            end
            // One long hold-off while the sender keeps pushing.
            if (results_seen == 300 && !long_hold_done) begin
               rsp_hold = 400;
               long_hold_done = 1'b1;
            end else begin
               rsp_hold = pick_gap();
            end
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles with no transfer on either side.
   int idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic push_op(input rhh_pkg::opcode_type op, input logic [63:0] key,
                          input logic [31:0] value);
      table_op_type t;
      t.op = op;
      t.key = key;
      t.value = value;
      pending_ops.push_back(t);
   endtask

   // Wait until every queued operation is sent and every result has arrived.
   task automatic wait_drained();
      while (pending_ops.size() > 0 || expected_results.size() > 0 || req_tvalid)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_limit(input logic [9:0] limit);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= limit;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      shadow_limit = limit;
   endtask

   // Keys crowd a few home slots near both ends of the table to force long runs and wrap.
   function automatic logic [63:0] fresh_key();
      logic [63:0] k;
      k = {$urandom, $urandom};
      if ($urandom_range(0, 1)) k[9:0] = 10'($urandom_range(0, 7));
      else k[9:0] = 10'($urandom_range(1016, 1023));
      return k;
   endfunction

   function automatic logic [63:0] pick_key();
      logic [63:0] k;
      if (key_pool.size() > 0 && $urandom_range(0, 99) < 70)
         return key_pool[$urandom_range(0, key_pool.size() - 1)];
      k = fresh_key();
      if (key_pool.size() < 48) key_pool.push_back(k);
      return k;
   endfunction

   initial begin
      int r;
      rhh_pkg::opcode_type op;
      logic [63:0] ka, kb, kc;
      for (int k = 0; k < SLOTS; k++) shadow_dist[k] = 0;
      shadow_count = 0;
      shadow_scan = 0;
      shadow_limit = rhh_pkg::MAX_ENTRIES_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: collisions at the top slot that wrap to slot 0, then displacement.
      ka = 64'hFFFF_FFFF_FFFF_FFFF;
      kb = 64'h0000_0000_0000_03FF;
      kc = 64'h0;
      push_op(rhh_pkg::OP_INSERT, ka, 32'hFFFF_FFFF);
      push_op(rhh_pkg::OP_INSERT, kb, 32'h0);
      push_op(rhh_pkg::OP_INSERT, kc, 32'h1234_5678);
      push_op(rhh_pkg::OP_INSERT, ka, 32'hA5A5_5A5A);
      push_op(rhh_pkg::OP_LOOKUP, ka, 32'hFFFF_FFFF);
      push_op(rhh_pkg::OP_LOOKUP, 64'hFFFF_0000_0000_0000, 32'h0);
      push_op(rhh_pkg::OP_NEXT, 64'h0, 32'h0);
      push_op(rhh_pkg::OP_NEXT, 64'h0, 32'h0);
      push_op(rhh_pkg::OP_NEXT, 64'h0, 32'h0);
      push_op(rhh_pkg::OP_NEXT, 64'h0, 32'h0);
      push_op(rhh_pkg::OP_NEXT, 64'h1, 32'h0);
      push_op(rhh_pkg::OP_RESTART, 64'h0, 32'h0);
      push_op(rhh_pkg::OP_NEXT, 64'h0, 32'h0);
      push_op(rhh_pkg::OP_DELETE, kb, 32'h0);
      push_op(rhh_pkg::OP_LOOKUP, kc, 32'h0);
      push_op(rhh_pkg::OP_DELETE, kb, 32'h0);
      push_op(rhh_pkg::OP_NEXT, 64'h0, 32'h0);
      push_op(rhh_pkg::OP_RSVD6, 64'h0123_4567_89AB_CDEF, 32'hFFFF_FFFF);
      push_op(rhh_pkg::OP_RSVD7, 64'hFEDC_BA98_7654_3210, 32'h0);
      push_op(rhh_pkg::OP_CLEAR, ka, 32'h0);
      push_op(rhh_pkg::OP_LOOKUP, ka, 32'h0);
      push_op(rhh_pkg::OP_NEXT, 64'h0, 32'h0);
      wait_drained();

      // Limit extremes: zero refuses every new key, one admits a single entry.
      write_limit(10'd0);
      push_op(rhh_pkg::OP_INSERT, kc, 32'h1);
      wait_drained();
      write_limit(10'd1);
      push_op(rhh_pkg::OP_INSERT, kc, 32'h2);
      push_op(rhh_pkg::OP_INSERT, kb, 32'h3);
      push_op(rhh_pkg::OP_INSERT, kc, 32'h4);
      wait_drained();

      // Random operations in chunks, with a new entry limit between chunks.
      for (int chunk = 0; chunk < 4; chunk++) begin
         write_limit(10'($urandom_range(4, 40)));
         for (int n = 0; n < 120; n++) begin
            r = $urandom_range(0, 99);
            if (r < 40) op = rhh_pkg::OP_INSERT;
            else if (r < 60) op = rhh_pkg::OP_LOOKUP;
            else if (r < 78) op = rhh_pkg::OP_DELETE;
            else if (r < 90) op = rhh_pkg::OP_NEXT;
            else if (r < 95) op = rhh_pkg::OP_RESTART;
            else if (r < 97) op = rhh_pkg::OP_CLEAR;
            else op = rhh_pkg::opcode_type'($urandom_range(6, 7));
            push_op(op, pick_key(), $urandom);
         end
         wait_drained();
      end

      // Fill up to the entry limit, after which new keys are refused.
      write_limit(10'd200);
      push_op(rhh_pkg::OP_CLEAR, 64'h0, 32'h0);
      for (int n = 0; n < 200; n++)
         push_op(rhh_pkg::OP_INSERT, {$urandom, 22'($urandom_range(0, 63)), 10'(n)},
                 $urandom);
      push_op(rhh_pkg::OP_INSERT, fresh_key(), $urandom);
      push_op(rhh_pkg::OP_INSERT, {$urandom, 22'($urandom), 10'd1023}, $urandom);
      push_op(rhh_pkg::OP_RESTART, 64'h0, 32'h0);
      push_op(rhh_pkg::OP_NEXT, 64'h0, 32'h0);
      push_op(rhh_pkg::OP_NEXT, 64'h0, 32'h0);
      push_op(rhh_pkg::OP_CLEAR, 64'h0, 32'h0);
      push_op(rhh_pkg::OP_NEXT, 64'h0, 32'h0);
      wait_drained();
      repeat (20) @(posedge clock);

      if (failures == 0 && expected_results.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
